FILE: hdl/dmb_pkg.sv
// ---------------------------------------------------------------------------
// dmb_pkg: shared constants, types and helpers of the diagonal blur filter
// Frame limits, line store geometry and the job word that the front hands
// to the back through the queue.
// ---------------------------------------------------------------------------
package dmb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_HALF   = 31;
    localparam int RING_ROWS  = 2 * MAX_HALF + 2;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WD_W    = $clog2(MAX_WIDTH + 1);
    localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int RING_W  = $clog2(RING_ROWS);
    localparam int ADDR_W  = $clog2(RING_ROWS * MAX_WIDTH);
    localparam int HALF_W  = $clog2(MAX_HALF + 1);
    localparam int TAP_W   = $clog2(2 * MAX_HALF + 2);
    localparam int DIV_W   = HALF_W + 1;
    localparam int SUM_W   = 8 + TAP_W;
    localparam int IDX_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PROD_W  = HALF_W + WD_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF   = 2'd2;

    // input codes
    localparam logic FUNC_PIXEL = 1'b0;

    // one unit of work for the back end
    typedef struct packed {
        logic                 store;
        logic [ADDR_W-1:0]    waddr;
        logic [7:0]           wdata;
        logic                 produce;
        logic [RING_W-1:0]    ring0;
        logic [COL_W-1:0]     col0;
        logic [TAP_W-1:0]     ntaps;
        logic [DIV_W-1:0]     divisor;
        logic                 frame_end;
    } dmb_job_t;

    // line store address of ring row / column
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [RING_W-1:0] ring,
                                                    input logic [COL_W-1:0] col);
        slot_addr = ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    // zero reads as one, large values saturate
    function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int hi);
        int vi;
        vi = int'(v);
        if (vi == 0) clamp_dim = 1;
        else if (vi > hi) clamp_dim = hi;
        else clamp_dim = vi;
    endfunction

    function automatic int min3(input int a, input int b, input int c);
        int m;
        m = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

endpackage

FILE: hdl/dmb_queue.sv
// ---------------------------------------------------------------------------
// dmb_queue: two-entry job queue
// Decouples the position tracker from the line store engine.
// ---------------------------------------------------------------------------
module dmb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dmb_pkg::dmb_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output dmb_pkg::dmb_job_t head_job,
    output logic [1:0]        count
);

    dmb_pkg::dmb_job_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_job = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    // storage and pointers
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: hdl/dmb_front.sv
// ---------------------------------------------------------------------------
// dmb_front: input acceptance and output scheduling
// Tracks input and output raster positions, decides whether a word stores a
// pixel and whether the next result is due, and queues a job for the back.
// ---------------------------------------------------------------------------
module dmb_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [7:0]                     s_pixel_in,
    input  logic                           cfg_valid,
    input  logic [dmb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmb_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           q_push,
    output dmb_pkg::dmb_job_t              q_job,
    input  logic                           q_full
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

    fstate_t state_reg, state_next;
    logic [dmb_pkg::CFG_DATA_W-1:0] width_cfg_reg, width_cfg_next;
    logic [dmb_pkg::CFG_DATA_W-1:0] height_cfg_reg, height_cfg_next;
    logic [4:0]                     half_cfg_reg, half_cfg_next;

    logic [dmb_pkg::COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [dmb_pkg::ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [dmb_pkg::RING_W-1:0] in_ring_reg, in_ring_next, out_ring_reg, out_ring_next;
    logic [dmb_pkg::IDX_W-1:0]  in_idx_reg, in_idx_next, out_idx_reg, out_idx_next;
    logic                       frame_done_reg, frame_done_next;

    logic [dmb_pkg::HALF_W-1:0] k_lo_reg, k_lo_next, k_hi_reg, k_hi_next;
    logic [dmb_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                       store_reg, store_next;
    logic [dmb_pkg::ADDR_W-1:0] waddr_reg, waddr_next;
    logic [7:0]                 wdata_reg, wdata_next;

    logic [dmb_pkg::WD_W-1:0]   w_c;
    logic [dmb_pkg::HT_W-1:0]   ht_c;
    logic [dmb_pkg::HALF_W-1:0] h_c;
    logic                       due;
    logic [dmb_pkg::RING_W:0]   ring_tmp;

    // clamped frame geometry
    assign w_c  = dmb_pkg::WD_W'(dmb_pkg::clamp_dim(width_cfg_reg, dmb_pkg::MAX_WIDTH));
    assign ht_c = dmb_pkg::HT_W'(dmb_pkg::clamp_dim(height_cfg_reg, dmb_pkg::MAX_HEIGHT));
    assign h_c  = (int'(half_cfg_reg) > dmb_pkg::MAX_HALF) ?
                  dmb_pkg::HALF_W'(dmb_pkg::MAX_HALF) : dmb_pkg::HALF_W'(half_cfg_reg);

    // next result due once its last tap has arrived
    assign due = frame_done_reg ||
                 ((dmb_pkg::IDX_W+1)'(in_idx_reg) >
                  (dmb_pkg::IDX_W+1)'(out_idx_reg) + (dmb_pkg::IDX_W+1)'(prod_reg));

    assign s_ready = (state_reg == F_IDLE);

    // ring row of the first tap
    always_comb begin
        if (out_ring_reg >= dmb_pkg::RING_W'(k_lo_reg)) begin
            ring_tmp = (dmb_pkg::RING_W+1)'(out_ring_reg) - (dmb_pkg::RING_W+1)'(k_lo_reg);
        end else begin
            ring_tmp = (dmb_pkg::RING_W+1)'(out_ring_reg)
                     + (dmb_pkg::RING_W+1)'(dmb_pkg::RING_ROWS)
                     - (dmb_pkg::RING_W+1)'(k_lo_reg);
        end
    end

    // job word
    always_comb begin
        q_job.store     = store_reg;
        q_job.waddr     = waddr_reg;
        q_job.wdata     = wdata_reg;
        q_job.produce   = due;
        q_job.ring0     = ring_tmp[dmb_pkg::RING_W-1:0];
        q_job.col0      = out_col_reg - dmb_pkg::COL_W'(k_lo_reg);
        q_job.ntaps     = dmb_pkg::TAP_W'(k_lo_reg) + dmb_pkg::TAP_W'(k_hi_reg) + 1'b1;
        q_job.divisor   = {h_c, 1'b1};
        q_job.frame_end = (32'(out_col_reg) + 1 >= 32'(w_c)) &&
                          (32'(out_row_reg) + 1 >= 32'(ht_c));
    end

    // sequencing and position update
    always_comb begin
        state_next      = state_reg;
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        half_cfg_next   = half_cfg_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        in_ring_next    = in_ring_reg;
        in_idx_next     = in_idx_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_ring_next   = out_ring_reg;
        out_idx_next    = out_idx_reg;
        frame_done_next = frame_done_reg;
        k_lo_next       = k_lo_reg;
        k_hi_next       = k_hi_reg;
        prod_next       = prod_reg;
        store_next      = store_reg;
        waddr_next      = waddr_reg;
        wdata_next      = wdata_reg;
        q_push          = 1'b0;

        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    store_next = (s_func == dmb_pkg::FUNC_PIXEL) && !frame_done_reg;
                    waddr_next = dmb_pkg::slot_addr(in_ring_reg, in_col_reg);
                    wdata_next = s_pixel_in;
                    if (store_next) begin
                        in_idx_next = in_idx_reg + 1'b1;
                        if (32'(in_col_reg) + 1 >= 32'(w_c)) begin
                            in_col_next = '0;
                            if (32'(in_row_reg) + 1 >= 32'(ht_c)) begin
                                in_row_next     = '0;
                                in_ring_next    = '0;
                                frame_done_next = 1'b1;
                            end else begin
                                in_row_next  = in_row_reg + 1'b1;
                                in_ring_next = (32'(in_ring_reg) == dmb_pkg::RING_ROWS - 1) ?
                                               '0 : in_ring_reg + 1'b1;
                            end
                        end else begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                    end
                    k_hi_next = dmb_pkg::HALF_W'(dmb_pkg::min3(int'(h_c),
                                int'(ht_c) - 1 - int'(out_row_reg),
                                int'(w_c) - 1 - int'(out_col_reg)));
                    k_lo_next = dmb_pkg::HALF_W'(dmb_pkg::min3(int'(h_c),
                                int'(out_row_reg), int'(out_col_reg)));
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                prod_next  = dmb_pkg::PROD_W'(k_hi_reg) * (dmb_pkg::PROD_W'(w_c) + 1'b1);
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!store_reg && !due) begin
                    state_next = F_IDLE;
                end else if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                    if (due) begin
                        out_idx_next = out_idx_reg + 1'b1;
                        if (32'(out_col_reg) + 1 >= 32'(w_c)) begin
                            out_col_next = '0;
                            if (32'(out_row_reg) + 1 >= 32'(ht_c)) begin
                                // frame complete: start over
                                in_col_next     = '0;
                                in_row_next     = '0;
                                in_ring_next    = '0;
                                in_idx_next     = '0;
                                out_row_next    = '0;
                                out_ring_next   = '0;
                                out_idx_next    = '0;
                                frame_done_next = 1'b0;
                            end else begin
                                out_row_next  = out_row_reg + 1'b1;
                                out_ring_next = (32'(out_ring_reg) == dmb_pkg::RING_ROWS - 1) ?
                                                '0 : out_ring_reg + 1'b1;
                            end
                        end else begin
                            out_col_next = out_col_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase

        // register write restarts the frame
        if (cfg_valid && (cfg_index == dmb_pkg::REG_WIDTH || cfg_index == dmb_pkg::REG_HEIGHT ||
                          cfg_index == dmb_pkg::REG_HALF)) begin
            if (cfg_index == dmb_pkg::REG_WIDTH)  width_cfg_next  = cfg_data;
            if (cfg_index == dmb_pkg::REG_HEIGHT) height_cfg_next = cfg_data;
            if (cfg_index == dmb_pkg::REG_HALF)   half_cfg_next   = cfg_data[4:0];
            in_col_next     = '0;
            in_row_next     = '0;
            in_ring_next    = '0;
            in_idx_next     = '0;
            out_col_next    = '0;
            out_row_next    = '0;
            out_ring_next   = '0;
            out_idx_next    = '0;
            frame_done_next = 1'b0;
        end
    end

    // state and position registers
    always_ff @(posedge aclk) begin
        k_lo_reg  <= k_lo_next;
        k_hi_reg  <= k_hi_next;
        prod_reg  <= prod_next;
        store_reg <= store_next;
        waddr_reg <= waddr_next;
        wdata_reg <= wdata_next;
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            width_cfg_reg  <= dmb_pkg::CFG_DATA_W'(1024);
            height_cfg_reg <= dmb_pkg::CFG_DATA_W'(1024);
            half_cfg_reg   <= 5'd20;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_ring_reg    <= '0;
            in_idx_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_ring_reg   <= '0;
            out_idx_reg    <= '0;
            frame_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            half_cfg_reg   <= half_cfg_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            in_ring_reg    <= in_ring_next;
            in_idx_reg     <= in_idx_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            out_ring_reg   <= out_ring_next;
            out_idx_reg    <= out_idx_next;
            frame_done_reg <= frame_done_next;
        end
    end

endmodule

FILE: hdl/dmb_back.sv
// ---------------------------------------------------------------------------
// dmb_back: line store, tap accumulation and division
// Stores the pixel of a job, reads its diagonal taps one a cycle, divides
// the sum by 2h+1 bit by bit and holds the result in the output register.
// ---------------------------------------------------------------------------
module dmb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  dmb_pkg::dmb_job_t q_job,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_pixel_out,
    output logic              m_frame_end
);

    localparam int STEP_W = $clog2(dmb_pkg::SUM_W + 1);

    typedef enum logic [2:0] {B_IDLE, B_READ, B_LAST, B_DIV, B_HOLD} bstate_t;

    bstate_t state_reg;
    logic [7:0] mem [dmb_pkg::RING_ROWS * dmb_pkg::MAX_WIDTH];
    logic [7:0] rd_data_reg;
    logic       rd_valid_reg;

    logic [dmb_pkg::RING_W-1:0] ring_reg;
    logic [dmb_pkg::COL_W-1:0]  col_reg;
    logic [dmb_pkg::TAP_W-1:0]  left_reg;
    logic [dmb_pkg::SUM_W-1:0]  acc_reg;
    logic [dmb_pkg::DIV_W-1:0]  div_reg;
    logic [dmb_pkg::DIV_W-1:0]  rem_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       fend_reg;
    logic                       m_valid_reg, m_frame_end_reg;
    logic [7:0]                 m_pixel_reg;

    logic                       mem_we, mem_re;
    logic [dmb_pkg::ADDR_W-1:0] raddr;
    logic [dmb_pkg::DIV_W:0]    rem_sh;
    logic                       q_bit;

    assign q_pop  = (state_reg == B_IDLE) && q_valid;
    assign mem_we = q_pop && q_job.store;
    assign mem_re = (state_reg == B_READ);
    assign raddr  = dmb_pkg::slot_addr(ring_reg, col_reg);

    // one restoring division step
    assign rem_sh = {rem_reg, acc_reg[dmb_pkg::SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, div_reg});

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_reg;
    assign m_frame_end = m_frame_end_reg;

    // line store
    always_ff @(posedge aclk) begin
        if (mem_we) mem[q_job.waddr] <= q_job.wdata;
        if (mem_re) rd_data_reg <= mem[raddr];
    end

    // tap and divide sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= mem_re;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE: begin
                    if (q_valid && q_job.produce) begin
                        ring_reg  <= q_job.ring0;
                        col_reg   <= q_job.col0;
                        left_reg  <= q_job.ntaps;
                        div_reg   <= q_job.divisor;
                        fend_reg  <= q_job.frame_end;
                        acc_reg   <= '0;
                        state_reg <= B_READ;
                    end
                end
                B_READ: begin
                    if (rd_valid_reg) acc_reg <= acc_reg + dmb_pkg::SUM_W'(rd_data_reg);
                    ring_reg <= (32'(ring_reg) == dmb_pkg::RING_ROWS - 1) ? '0 : ring_reg + 1'b1;
                    col_reg  <= col_reg + 1'b1;
                    left_reg <= left_reg - 1'b1;
                    if (left_reg == dmb_pkg::TAP_W'(1)) state_reg <= B_LAST;
                end
                B_LAST: begin
                    acc_reg   <= acc_reg + dmb_pkg::SUM_W'(rd_data_reg);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    // quotient bits shift in from the bottom
                    rem_reg  <= q_bit ? dmb_pkg::DIV_W'(rem_sh - {1'b0, div_reg})
                                      : rem_sh[dmb_pkg::DIV_W-1:0];
                    acc_reg  <= {acc_reg[dmb_pkg::SUM_W-2:0], q_bit};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(dmb_pkg::SUM_W - 1)) state_reg <= B_HOLD;
                end
                B_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_pixel_reg     <= acc_reg[7:0];
                        m_frame_end_reg <= fend_reg;
                        state_reg       <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/diagonal_motion_blur_filter_top.sv
// ---------------------------------------------------------------------------
// diagonal_motion_blur_filter_top: diagonal box blur over a raster stream
// Input words carry 8-bit pixels in raster order (s_func = 0) or drain ticks
// (s_func = 1). Each word yields at most one result word on the m_ channel:
// the mean of the 2h+1 pixels on the main diagonal through the next raster
// position, taps outside the frame counted as zero, m_frame_end on the last
// result of a frame. Drain ticks after the frame let the last h rows out.
// The cfg channel writes width (0), height (1) and half length (2); any such
// write restarts the frame. cfg_ready is always high; write only when idle.
// The front takes each word through F_IDLE, F_MUL and F_PUSH, so takes no
// new word before that. The back passes B_IDLE, B_READ (n taps inside the
// frame, up to 63, single read port), B_LAST, B_DIV (bit-serial), B_HOLD.
// A two-word job queue and the output register let the front keep taking
// words while a result waits; a stalled m_ready fills the queue and then
// holds s_ready low. Reset clears positions and registers to 1024, 1024,
// 20; line store contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module diagonal_motion_blur_filter_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [7:0]                     s_pixel_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_pixel_out,
    output logic                           m_frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dmb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmb_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic              q_push, q_full, q_pop, q_valid;
    logic [1:0]        q_count;
    dmb_pkg::dmb_job_t push_job, head_job;

    assign cfg_ready = 1'b1;

    dmb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_pixel_in (s_pixel_in),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_job      (push_job),
        .q_full     (q_full)
    );

    dmb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (head_job),
        .count    (q_count)
    );

    dmb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_frame_end (m_frame_end)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count != 2'd3)
        else $error("job queue count out of range");

    // no pop from an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_count != 2'd0)
        else $error("job popped from empty queue");

    // front is busy right after taking a word
    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front accepted back-to-back words");

endmodule
